// ===== rtl/line_follow_obstacle_controller_unit_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef LINE_FOLLOW_OBSTACLE_CONTROLLER_UNIT_MACROS_SVH
`define LINE_FOLLOW_OBSTACLE_CONTROLLER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFOC_ASSERT_SAME(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LFOC_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lfoc_pkg.sv =====
package lfoc_pkg;

  // Field widths.
  localparam int IR_W       = 10;
  localparam int DIST_W     = 13;
  localparam int PERIOD_W   = 10;
  localparam int TIME_W     = 16;
  localparam int SPEED_W    = 5;
  localparam int CMD_W      = 3;
  localparam int LED_W      = 2;
  localparam int STATUS_W   = 4;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int ADC_BITS_DEF = 10;

  // Drive commands.
  localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FWD   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd4;

  // LED colors.
  localparam logic [LED_W-1:0] LED_KEEP  = 2'd0;
  localparam logic [LED_W-1:0] LED_GREEN = 2'd1;
  localparam logic [LED_W-1:0] LED_BLUE  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_ENTER_FOLLOW = 4'd0;
  localparam logic [STATUS_W-1:0] ST_OBSTACLE     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_CREEP        = 4'd2;
  localparam logic [STATUS_W-1:0] ST_RIGHT_STRONG = 4'd3;
  localparam logic [STATUS_W-1:0] ST_LEFT_STRONG  = 4'd4;
  localparam logic [STATUS_W-1:0] ST_BOTH_ON      = 4'd5;
  localparam logic [STATUS_W-1:0] ST_TURNING      = 4'd6;
  localparam logic [STATUS_W-1:0] ST_TURN_DONE    = 4'd7;
  localparam logic [STATUS_W-1:0] ST_SEARCHING    = 4'd8;

  // Mode codes as reported on the result channel.
  localparam logic [MODE_W-1:0] MODE_CODE_STARTUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_FOLLOW  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_TURN    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CODE_SEARCH  = 2'd3;

  localparam logic [SPEED_W-1:0] TURN_SPEED = 5'd30;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECIDE_PERIOD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_TIME      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_HOLD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CREEP_SPEED    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CORRECT_SPEED  = 3'd6;

  // Configuration reset values.
  localparam logic [IR_W-1:0]     RST_GRAY_THRESHOLD = 10'd100;
  localparam logic [DIST_W-1:0]   RST_NEAR_LIMIT     = 13'd260;
  localparam logic [PERIOD_W-1:0] RST_DECIDE_PERIOD  = 10'd80;
  localparam logic [TIME_W-1:0]   RST_TURN_TIME      = 16'd5500;
  localparam logic [TIME_W-1:0]   RST_STARTUP_HOLD   = 16'd2000;
  localparam logic [SPEED_W-1:0]  RST_CREEP_SPEED    = 5'd4;
  localparam logic [SPEED_W-1:0]  RST_CORRECT_SPEED  = 5'd12;

  typedef enum logic [3:0] {
    MODE_STARTUP = 4'b0001,
    MODE_FOLLOW  = 4'b0010,
    MODE_TURN    = 4'b0100,
    MODE_SEARCH  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [IR_W-1:0]   left_ir;
    logic [IR_W-1:0]   right_ir;
    logic [DIST_W-1:0] distance;
  } in_t;

  typedef struct packed {
    logic [CMD_W-1:0]    drive_cmd;
    logic [SPEED_W-1:0]  drive_speed;
    logic [LED_W-1:0]    led_color;
    logic [STATUS_W-1:0] status;
    logic [MODE_W-1:0]   mode;
  } out_t;

  typedef struct packed {
    logic [IR_W-1:0]     gray_threshold;
    logic [DIST_W-1:0]   near_limit;
    logic [PERIOD_W-1:0] decide_period;
    logic [TIME_W-1:0]   turn_time;
    logic [TIME_W-1:0]   startup_hold;
    logic [SPEED_W-1:0]  creep_speed;
    logic [SPEED_W-1:0]  correct_speed;
  } cfg_t;

  typedef struct packed {
    mode_t               mode;
    logic [PERIOD_W-1:0] since;
    logic [TIME_W-1:0]   turn;
    logic [TIME_W-1:0]   hold;
  } st_t;

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] code;
    case (m)
      MODE_STARTUP: code = MODE_CODE_STARTUP;
      MODE_FOLLOW:  code = MODE_CODE_FOLLOW;
      MODE_TURN:    code = MODE_CODE_TURN;
      default:      code = MODE_CODE_SEARCH;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/line_follow_obstacle_controller_unit.sv =====
// Line-follow controller with obstacle avoidance, one sensor tick per transaction.
// Input channel (in_valid, in_stall, in_data): each transaction carries the two IR
// line-sensor samples and the ultrasonic distance of one millisecond tick.
// Result channel (out_valid, out_stall, out_data): one transaction per decision,
// none for ticks that fall between decisions or inside the startup hold.
// Configuration port (cfg_we, cfg_index, cfg_wdata): one register written per
// cycle with cfg_we high; indexes past the last register are ignored. Write it
// only while no tick is in flight.
// A tick accepted into the input register is evaluated there and, unless a
// stalled result blocks it, its result is loaded into the output register.
// Throughput: one tick per cycle while no stalled result holds the input register,
// set by the single compare-and-count pass between the input and output registers.
// Reset (rst_n low at a clock edge) empties both registers, loads the register
// defaults and puts the controller in startup mode with all counters at zero.
// When the receiver stalls, the result stays in the output register; ticks that
// produce no result keep flowing, and in_stall rises only once a second result
// is ready behind the stalled one.
module line_follow_obstacle_controller_unit #(
  parameter int ADC_BITS = lfoc_pkg::ADC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lfoc_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lfoc_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [lfoc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfoc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // Input register holding the tick under evaluation.
  logic           in_vld_r;
  logic           in_vld_nxt;
  lfoc_pkg::in_t  in_item_r;

  // Controller state: mode, tick counters and startup hold.
  lfoc_pkg::st_t  st_r;
  lfoc_pkg::st_t  st_nxt;

  // Output register.
  logic           out_vld_r;
  logic           out_vld_nxt;
  lfoc_pkg::out_t out_data_r;

  lfoc_pkg::cfg_t cfg;
  lfoc_pkg::out_t res;
  logic           emit;
  logic           out_free;
  logic           advance;
  logic           in_take;

  lfoc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lfoc_decide #(
    .ADC_BITS (ADC_BITS)
  ) u_decide (
    .item   (in_item_r),
    .st     (st_r),
    .cfg    (cfg),
    .emit   (emit),
    .res    (res),
    .st_nxt (st_nxt)
  );

  // The held tick retires when it produces nothing, or when the output register
  // is empty or being drained this cycle.
  assign out_free = !out_vld_r || !out_stall;
  assign advance  = in_vld_r && (!emit || out_free);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance && emit) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      st_r.mode  <= lfoc_pkg::MODE_STARTUP;
      st_r.since <= '0;
      st_r.turn  <= '0;
      st_r.hold  <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (advance && emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/lfoc_cfg.sv =====
module lfoc_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lfoc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfoc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output lfoc_pkg::cfg_t                    cfg
);

  lfoc_pkg::cfg_t cfg_r;
  lfoc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        lfoc_pkg::REG_GRAY_THRESHOLD:
          cfg_nxt.gray_threshold = cfg_wdata[lfoc_pkg::IR_W-1:0];
        lfoc_pkg::REG_NEAR_LIMIT:
          cfg_nxt.near_limit = cfg_wdata[lfoc_pkg::DIST_W-1:0];
        lfoc_pkg::REG_DECIDE_PERIOD:
          cfg_nxt.decide_period = cfg_wdata[lfoc_pkg::PERIOD_W-1:0];
        lfoc_pkg::REG_TURN_TIME:
          cfg_nxt.turn_time = cfg_wdata[lfoc_pkg::TIME_W-1:0];
        lfoc_pkg::REG_STARTUP_HOLD:
          cfg_nxt.startup_hold = cfg_wdata[lfoc_pkg::TIME_W-1:0];
        lfoc_pkg::REG_CREEP_SPEED:
          cfg_nxt.creep_speed = cfg_wdata[lfoc_pkg::SPEED_W-1:0];
        lfoc_pkg::REG_CORRECT_SPEED:
          cfg_nxt.correct_speed = cfg_wdata[lfoc_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gray_threshold <= lfoc_pkg::RST_GRAY_THRESHOLD;
      cfg_r.near_limit     <= lfoc_pkg::RST_NEAR_LIMIT;
      cfg_r.decide_period  <= lfoc_pkg::RST_DECIDE_PERIOD;
      cfg_r.turn_time      <= lfoc_pkg::RST_TURN_TIME;
      cfg_r.startup_hold   <= lfoc_pkg::RST_STARTUP_HOLD;
      cfg_r.creep_speed    <= lfoc_pkg::RST_CREEP_SPEED;
      cfg_r.correct_speed  <= lfoc_pkg::RST_CORRECT_SPEED;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/lfoc_decide.sv =====
module lfoc_decide #(
  parameter int ADC_BITS = lfoc_pkg::ADC_BITS_DEF
) (
  input  lfoc_pkg::in_t  item,
  input  lfoc_pkg::st_t  st,
  input  lfoc_pkg::cfg_t cfg,
  output logic           emit,
  output lfoc_pkg::out_t res,
  output lfoc_pkg::st_t  st_nxt
);

  localparam int IrW = lfoc_pkg::IR_W;
  localparam logic [IrW-1:0] AdcMask =
    (ADC_BITS >= IrW) ? {IrW{1'b1}} : IrW'((1 << ADC_BITS) - 1);

  logic [IrW-1:0]                l_smp;
  logic [IrW-1:0]                r_smp;
  logic                          lon;
  logic                          ron;
  logic                          near;
  logic [lfoc_pkg::PERIOD_W-1:0] since_inc;
  logic [lfoc_pkg::TIME_W-1:0]   turn_inc;

  assign l_smp = item.left_ir & AdcMask;
  assign r_smp = item.right_ir & AdcMask;
  assign lon   = l_smp > cfg.gray_threshold;
  assign ron   = r_smp > cfg.gray_threshold;
  assign near  = item.distance < cfg.near_limit;

  // Both tick counters saturate at their all-ones value.
  assign since_inc = (st.since != '1) ? st.since + 1'b1 : st.since;
  assign turn_inc  = ((st.mode == lfoc_pkg::MODE_TURN) && (st.turn != '1)) ?
                     st.turn + 1'b1 : st.turn;

  always_comb begin
    st_nxt          = st;
    st_nxt.since    = since_inc;
    st_nxt.turn     = turn_inc;
    emit            = 1'b0;
    res.drive_cmd   = lfoc_pkg::CMD_NONE;
    res.drive_speed = '0;
    res.led_color   = lfoc_pkg::LED_KEEP;
    res.status      = lfoc_pkg::ST_ENTER_FOLLOW;

    if (st.hold != '0) begin
      st_nxt.hold = st.hold - 1'b1;
    end else if (since_inc >= cfg.decide_period) begin
      emit         = 1'b1;
      st_nxt.since = '0;
      case (st.mode)
        lfoc_pkg::MODE_STARTUP: begin
          st_nxt.mode   = lfoc_pkg::MODE_FOLLOW;
          st_nxt.hold   = cfg.startup_hold;
          res.drive_cmd = lfoc_pkg::CMD_STOP;
          res.led_color = lfoc_pkg::LED_GREEN;
          res.status    = lfoc_pkg::ST_ENTER_FOLLOW;
        end
        lfoc_pkg::MODE_FOLLOW: begin
          if (near) begin
            st_nxt.mode   = lfoc_pkg::MODE_TURN;
            st_nxt.turn   = '0;
            res.drive_cmd = lfoc_pkg::CMD_STOP;
            res.led_color = lfoc_pkg::LED_BLUE;
            res.status    = lfoc_pkg::ST_OBSTACLE;
          end else if (!lon && !ron) begin
            res.drive_cmd   = lfoc_pkg::CMD_FWD;
            res.drive_speed = cfg.creep_speed;
            res.status      = lfoc_pkg::ST_CREEP;
          end else if (lon && !ron) begin
            res.drive_cmd   = lfoc_pkg::CMD_RIGHT;
            res.drive_speed = cfg.correct_speed;
            res.status      = lfoc_pkg::ST_RIGHT_STRONG;
          end else if (!lon && ron) begin
            res.drive_cmd   = lfoc_pkg::CMD_LEFT;
            res.drive_speed = cfg.correct_speed;
            res.status      = lfoc_pkg::ST_LEFT_STRONG;
          end else begin
            res.drive_cmd   = lfoc_pkg::CMD_RIGHT;
            res.drive_speed = cfg.creep_speed;
            res.status      = lfoc_pkg::ST_BOTH_ON;
          end
        end
        lfoc_pkg::MODE_TURN: begin
          if (turn_inc >= cfg.turn_time) begin
            st_nxt.mode   = lfoc_pkg::MODE_SEARCH;
            res.drive_cmd = lfoc_pkg::CMD_STOP;
            res.status    = lfoc_pkg::ST_TURN_DONE;
          end else begin
            res.drive_cmd   = lfoc_pkg::CMD_RIGHT;
            res.drive_speed = lfoc_pkg::TURN_SPEED;
            res.status      = lfoc_pkg::ST_TURNING;
          end
        end
        default: begin
          if (near) begin
            st_nxt.mode   = lfoc_pkg::MODE_TURN;
            st_nxt.turn   = '0;
            res.drive_cmd = lfoc_pkg::CMD_STOP;
            res.led_color = lfoc_pkg::LED_BLUE;
            res.status    = lfoc_pkg::ST_OBSTACLE;
          end else if (lon || ron) begin
            st_nxt.mode   = lfoc_pkg::MODE_FOLLOW;
            res.led_color = lfoc_pkg::LED_GREEN;
            res.status    = lfoc_pkg::ST_ENTER_FOLLOW;
          end else begin
            res.drive_cmd   = lfoc_pkg::CMD_FWD;
            res.drive_speed = cfg.creep_speed;
            res.status      = lfoc_pkg::ST_SEARCHING;
          end
        end
      endcase
    end
    res.mode = lfoc_pkg::mode_code(st_nxt.mode);
  end

endmodule

// ===== rtl/lfoc_checker.sv =====
`include "line_follow_obstacle_controller_unit_macros.svh"

module lfoc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input lfoc_pkg::out_t                    out_data
);

  logic out_held;
  logic in_held;
  logic idle_cmd;
  logic obst_res;
  logic obst_ok;

  assign out_held = rst_n && out_valid && out_stall;
  assign in_held  = rst_n && in_stall;
  assign idle_cmd = out_valid && (out_data.drive_cmd == lfoc_pkg::CMD_STOP ||
                                  out_data.drive_cmd == lfoc_pkg::CMD_NONE);
  assign obst_res = out_valid && (out_data.status == lfoc_pkg::ST_OBSTACLE);
  assign obst_ok  = (out_data.drive_cmd == lfoc_pkg::CMD_STOP) &&
                    (out_data.led_color == lfoc_pkg::LED_BLUE) &&
                    (out_data.mode == lfoc_pkg::MODE_CODE_TURN);

  // Reset empties the result channel.
  `LFOC_ASSERT_NEXT(a_reset_empty, clk, !rst_n, !out_valid, "result valid after reset")

  // A stalled result transaction holds.
  `LFOC_ASSERT_NEXT(a_out_hold, clk, out_held, out_valid && $stable(out_data), "stalled result changed")

  // The input only backs up behind a result that the receiver is holding off.
  `LFOC_ASSERT_SAME(a_in_stall_cause, clk, in_held, out_valid && out_stall, "input stall without blocked result")

  // Stop and no-command decisions never carry a speed.
  `LFOC_ASSERT_SAME(a_idle_speed, clk, idle_cmd, out_data.drive_speed == '0, "speed with stop or none")

  // An obstacle always stops the vehicle, lights blue and enters the turn.
  `LFOC_ASSERT_SAME(a_obstacle, clk, obst_res, obst_ok, "bad obstacle result")

endmodule

bind line_follow_obstacle_controller_unit lfoc_checker u_lfoc_checker (.*);

// ===== test/tb.sv =====
module tb;

  localparam int IrW    = lfoc_pkg::IR_W;
  localparam int DistW  = lfoc_pkg::DIST_W;
  localparam int PerW   = lfoc_pkg::PERIOD_W;
  localparam int TimeW  = lfoc_pkg::TIME_W;
  localparam int SpeedW = lfoc_pkg::SPEED_W;

  logic                                clk;
  logic                                rst_n     = 1'b0;
  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  lfoc_pkg::in_t                       in_data   = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  lfoc_pkg::out_t                      out_data;
  logic                                cfg_we    = 1'b0;
  logic [lfoc_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [lfoc_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;

  line_follow_obstacle_controller_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ticks waiting to be driven and decisions waiting to come out.
  lfoc_pkg::in_t  tick_q[$];
  lfoc_pkg::out_t decision_q[$];

  int unsigned mismatches = 0;
  bit          idle_on    = 1'b1;
  bit          in_took    = 1'b0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;

  // Controller state and registers as the testbench expects them.
  lfoc_pkg::cfg_t                ctl_cfg;
  logic [lfoc_pkg::MODE_W-1:0]   ctl_mode;
  int unsigned                   since_cnt;
  int unsigned                   turn_cnt;
  int unsigned                   hold_cnt;

  task automatic note_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      note_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  function automatic lfoc_pkg::out_t make_out(
      input logic [lfoc_pkg::CMD_W-1:0]    cmd,
      input logic [lfoc_pkg::SPEED_W-1:0]  spd,
      input logic [lfoc_pkg::LED_W-1:0]    led,
      input logic [lfoc_pkg::STATUS_W-1:0] st);
    lfoc_pkg::out_t o;
    o.drive_cmd   = cmd;
    o.drive_speed = spd;
    o.led_color   = led;
    o.status      = st;
    o.mode        = '0;
    return o;
  endfunction

  // An obstacle stops the robot, lights blue and starts the timed right turn.
  function automatic lfoc_pkg::out_t start_turn();
    ctl_mode = lfoc_pkg::MODE_CODE_TURN;
    turn_cnt = 0;
    return make_out(lfoc_pkg::CMD_STOP, '0, lfoc_pkg::LED_BLUE, lfoc_pkg::ST_OBSTACLE);
  endfunction

  // Advances the controller by one tick; returns 1 when the tick makes a decision.
  function automatic bit predict_decision(input lfoc_pkg::in_t t,
                                          output lfoc_pkg::out_t res);
    bit lon, ron, near;
    lon  = t.left_ir > ctl_cfg.gray_threshold;
    ron  = t.right_ir > ctl_cfg.gray_threshold;
    near = t.distance < ctl_cfg.near_limit;
    res  = '0;
    if (since_cnt < 1023) since_cnt++;
    if (ctl_mode == lfoc_pkg::MODE_CODE_TURN && turn_cnt < 65535) turn_cnt++;
    if (hold_cnt != 0) begin
      hold_cnt--;
      return 1'b0;
    end
    if (since_cnt < ctl_cfg.decide_period) return 1'b0;
    since_cnt = 0;
    case (ctl_mode)
      lfoc_pkg::MODE_CODE_STARTUP: begin
        ctl_mode = lfoc_pkg::MODE_CODE_FOLLOW;
        hold_cnt = 32'(ctl_cfg.startup_hold);
        res = make_out(lfoc_pkg::CMD_STOP, '0, lfoc_pkg::LED_GREEN,
                       lfoc_pkg::ST_ENTER_FOLLOW);
      end
      lfoc_pkg::MODE_CODE_FOLLOW: begin
        if (near) res = start_turn();
        else if (!lon && !ron)
          res = make_out(lfoc_pkg::CMD_FWD, ctl_cfg.creep_speed, lfoc_pkg::LED_KEEP,
                         lfoc_pkg::ST_CREEP);
        else if (lon && !ron)
          res = make_out(lfoc_pkg::CMD_RIGHT, ctl_cfg.correct_speed, lfoc_pkg::LED_KEEP,
                         lfoc_pkg::ST_RIGHT_STRONG);
        else if (!lon && ron)
          res = make_out(lfoc_pkg::CMD_LEFT, ctl_cfg.correct_speed, lfoc_pkg::LED_KEEP,
                         lfoc_pkg::ST_LEFT_STRONG);
        else
          res = make_out(lfoc_pkg::CMD_RIGHT, ctl_cfg.creep_speed, lfoc_pkg::LED_KEEP,
                         lfoc_pkg::ST_BOTH_ON);
      end
      lfoc_pkg::MODE_CODE_TURN: begin
        if (turn_cnt >= ctl_cfg.turn_time) begin
          ctl_mode = lfoc_pkg::MODE_CODE_SEARCH;
          res = make_out(lfoc_pkg::CMD_STOP, '0, lfoc_pkg::LED_KEEP,
                         lfoc_pkg::ST_TURN_DONE);
        end else begin
          res = make_out(lfoc_pkg::CMD_RIGHT, lfoc_pkg::TURN_SPEED, lfoc_pkg::LED_KEEP,
                         lfoc_pkg::ST_TURNING);
        end
      end
      default: begin
        if (near) res = start_turn();
        else if (lon || ron) begin
          ctl_mode = lfoc_pkg::MODE_CODE_FOLLOW;
          res = make_out(lfoc_pkg::CMD_NONE, '0, lfoc_pkg::LED_GREEN,
                         lfoc_pkg::ST_ENTER_FOLLOW);
        end else begin
          res = make_out(lfoc_pkg::CMD_FWD, ctl_cfg.creep_speed, lfoc_pkg::LED_KEEP,
                         lfoc_pkg::ST_SEARCHING);
        end
      end
    endcase
    res.mode = ctl_mode;
    return 1'b1;
  endfunction

  // Monitor: checks the result transaction of this edge, tracks register writes
  // and predicts the decision of every accepted tick.
  always @(posedge clk) begin : monitor
    lfoc_pkg::out_t got, want, res;
    if (!rst_n) begin
      ctl_cfg.gray_threshold = lfoc_pkg::RST_GRAY_THRESHOLD;
      ctl_cfg.near_limit     = lfoc_pkg::RST_NEAR_LIMIT;
      ctl_cfg.decide_period  = lfoc_pkg::RST_DECIDE_PERIOD;
      ctl_cfg.turn_time      = lfoc_pkg::RST_TURN_TIME;
      ctl_cfg.startup_hold   = lfoc_pkg::RST_STARTUP_HOLD;
      ctl_cfg.creep_speed    = lfoc_pkg::RST_CREEP_SPEED;
      ctl_cfg.correct_speed  = lfoc_pkg::RST_CORRECT_SPEED;
      ctl_mode  = lfoc_pkg::MODE_CODE_STARTUP;
      since_cnt = 0;
      turn_cnt  = 0;
      hold_cnt  = 0;
      in_took   = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (decision_q.size() == 0) begin
          note_mismatch($sformatf("result %h with no decision pending", got));
        end else begin
          want = decision_q.pop_front();
          check_field("drive_cmd", 32'(got.drive_cmd), 32'(want.drive_cmd));
          check_field("drive_speed", 32'(got.drive_speed), 32'(want.drive_speed));
          check_field("led_color", 32'(got.led_color), 32'(want.led_color));
          check_field("status", 32'(got.status), 32'(want.status));
          check_field("mode", 32'(got.mode), 32'(want.mode));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          lfoc_pkg::REG_GRAY_THRESHOLD: ctl_cfg.gray_threshold = cfg_wdata[IrW-1:0];
          lfoc_pkg::REG_NEAR_LIMIT:     ctl_cfg.near_limit     = cfg_wdata[DistW-1:0];
          lfoc_pkg::REG_DECIDE_PERIOD:  ctl_cfg.decide_period  = cfg_wdata[PerW-1:0];
          lfoc_pkg::REG_TURN_TIME:      ctl_cfg.turn_time      = cfg_wdata[TimeW-1:0];
          lfoc_pkg::REG_STARTUP_HOLD:   ctl_cfg.startup_hold   = cfg_wdata[TimeW-1:0];
          lfoc_pkg::REG_CREEP_SPEED:    ctl_cfg.creep_speed    = cfg_wdata[SpeedW-1:0];
          lfoc_pkg::REG_CORRECT_SPEED:  ctl_cfg.correct_speed  = cfg_wdata[SpeedW-1:0];
          default: ;
        endcase
      end
      in_took = in_valid && !in_stall;
      if (in_took && predict_decision(in_data, res)) decision_q.push_back(res);
    end
  end

  // Driver: a stalled transaction is held; otherwise the next tick goes out,
  // now and then after a burst of idle cycles.
  always @(negedge clk) begin : drive_ticks
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // Hold the stalled transaction unchanged.
    end else if (gap_left != 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (tick_q.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
      gap_left = $urandom_range(0, 8);
      in_valid <= 1'b0;
    end else if (tick_q.size() != 0) begin
      in_valid <= 1'b1;
      in_data  <= tick_q.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin : drive_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic lfoc_pkg::in_t mk_tick(input int unsigned l, input int unsigned r,
                                            input int unsigned d);
    lfoc_pkg::in_t t;
    t.left_ir  = IrW'(l);
    t.right_ir = IrW'(r);
    t.distance = DistW'(d);
    return t;
  endfunction

  // Half the samples are anywhere, half sit within two of the line threshold.
  function automatic logic [lfoc_pkg::IR_W-1:0] pick_ir();
    int v;
    if ($urandom_range(0, 1)) return IrW'($urandom_range(0, 1023));
    v = int'(ctl_cfg.gray_threshold) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return IrW'(v);
  endfunction

  function automatic lfoc_pkg::in_t rand_tick(input int unsigned near_pct);
    lfoc_pkg::in_t t;
    t.left_ir  = pick_ir();
    t.right_ir = pick_ir();
    if (ctl_cfg.near_limit != 0 && $urandom_range(0, 99) < near_pct)
      t.distance = DistW'($urandom_range(0, int'(ctl_cfg.near_limit) - 1));
    else
      t.distance = DistW'($urandom_range(int'(ctl_cfg.near_limit), 8191));
    return t;
  endfunction

  task automatic put_reg(input logic [lfoc_pkg::CFG_IDX_W-1:0] idx,
                         input logic [lfoc_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic write_cfg(input lfoc_pkg::cfg_t c);
    put_reg(lfoc_pkg::REG_GRAY_THRESHOLD, 16'(c.gray_threshold));
    put_reg(lfoc_pkg::REG_NEAR_LIMIT, 16'(c.near_limit));
    put_reg(lfoc_pkg::REG_DECIDE_PERIOD, 16'(c.decide_period));
    put_reg(lfoc_pkg::REG_TURN_TIME, c.turn_time);
    put_reg(lfoc_pkg::REG_STARTUP_HOLD, c.startup_hold);
    put_reg(lfoc_pkg::REG_CREEP_SPEED, 16'(c.creep_speed));
    put_reg(lfoc_pkg::REG_CORRECT_SPEED, 16'(c.correct_speed));
    cfg_we <= 1'b0;
  endtask

  // Lets every queued tick go out and every decision arrive, then waits on for a
  // tick that is still inside the block without a result.
  task automatic wait_idle();
    int unsigned spins;
    spins = 0;
    while (tick_q.size() != 0) @(negedge clk);
    @(negedge clk);
    while ((in_valid || decision_q.size() != 0) && spins < 500) begin
      @(negedge clk);
      spins++;
    end
    if (spins == 500) begin
      note_mismatch($sformatf("%0d decisions never arrived", decision_q.size()));
      decision_q.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    lfoc_pkg::cfg_t c;
    int unsigned    n_items;
    int unsigned    near_pct;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Register defaults with a short startup hold: the startup stop at the
    // default period, the hold, then decisions at the default period.
    put_reg(lfoc_pkg::REG_STARTUP_HOLD, 16'd100);
    cfg_we <= 1'b0;
    repeat (200) tick_q.push_back(rand_tick(3));
    wait_idle();

    // Directed ticks, one decision each: every steering case, the threshold
    // and distance edges, an obstacle in follow and in search, the turn and
    // its end, searching and finding the line.
    c = '{gray_threshold: 512, near_limit: 1000, decide_period: 1, turn_time: 2,
          startup_hold: 0, creep_speed: 31, correct_speed: 17};
    write_cfg(c);
    repeat (3) tick_q.push_back(mk_tick(0, 0, 8191));
    tick_q.push_back(mk_tick(1023, 1023, 8191));
    tick_q.push_back(mk_tick(0, 0, 8191));
    tick_q.push_back(mk_tick(1023, 0, 8191));
    tick_q.push_back(mk_tick(0, 1023, 8191));
    tick_q.push_back(mk_tick(512, 513, 1000));
    tick_q.push_back(mk_tick(513, 512, 999));
    repeat (3) tick_q.push_back(mk_tick(0, 0, 8191));
    tick_q.push_back(mk_tick(0, 0, 0));
    repeat (3) tick_q.push_back(mk_tick(0, 0, 8191));
    tick_q.push_back(mk_tick(0, 1023, 8191));
    tick_q.push_back(mk_tick(1023, 1023, 8191));
    tick_q.push_back(mk_tick(0, 0, 8191));
    tick_q.push_back(mk_tick(1023, 0, 0));
    wait_idle();

    // Random phases, each under its own register setting.
    for (int p = 0; p < 10; p++) begin
      c.gray_threshold = IrW'($urandom_range(0, 1023));
      c.near_limit     = DistW'($urandom_range(0, 8191));
      c.decide_period  = PerW'($urandom_range(1, 6));
      c.turn_time      = TimeW'($urandom_range(0, 12));
      c.startup_hold   = TimeW'($urandom_range(0, 65535));
      c.creep_speed    = SpeedW'($urandom_range(0, 31));
      c.correct_speed  = SpeedW'($urandom_range(0, 31));
      n_items  = 35;
      near_pct = 8;
      case (p)
        0: begin
          c.gray_threshold = 0;
          c.near_limit     = 8191;
          c.decide_period  = 1;
          c.turn_time      = 0;
          c.startup_hold   = 0;
          c.creep_speed    = 0;
          c.correct_speed  = 31;
          near_pct = 10;
        end
        1: begin
          c.gray_threshold = 1023;
          c.near_limit     = 0;
          c.decide_period  = 3;
          c.turn_time      = 65535;
          c.startup_hold   = 65535;
          c.creep_speed    = 31;
          c.correct_speed  = 0;
          near_pct = 0;
        end
        2: begin
          // A long decision period.
          c.decide_period = 100;
          n_items  = 220;
          near_pct = 3;
        end
        3: begin
          // A turn that cannot end inside the phase.
          c.near_limit    = 4000;
          c.decide_period = 1;
          c.turn_time     = 65535;
          n_items  = 80;
          near_pct = 20;
        end
        4: begin
          // A zero period decides on every tick; a zero turn time ends the
          // turn at the next decision.
          c.decide_period = 0;
          c.turn_time     = 0;
          near_pct = 10;
        end
        default: ;
      endcase
      if (p == 9) idle_on = 1'b0;
      write_cfg(c);
      repeat (n_items) tick_q.push_back(rand_tick(near_pct));
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== line_follow_obstacle_controller_unit.f =====
+incdir+rtl
rtl/lfoc_pkg.sv
rtl/lfoc_cfg.sv
rtl/lfoc_decide.sv
rtl/line_follow_obstacle_controller_unit.sv
rtl/lfoc_checker.sv
test/tb.sv
